[hw/rtl/tawac_pkg.sv]
// Shared types, sizes and codes for the three-window average anomaly classifier.
package tawac_pkg;

    // Samples per block.
    localparam int BLOCK_LEN = 16;

    // Field widths.
    localparam int FACTOR_W    = 24;
    localparam int SECONDS_W   = 32;
    localparam int HACK_W      = 23;
    localparam int LEVEL_W     = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    // A block sum of BLOCK_LEN samples stays exact at this width.
    localparam int SUM_W  = FACTOR_W + $clog2(BLOCK_LEN);
    // Comparison width: holds differences of sums and the scaled thresholds.
    localparam int CMP_W  = SUM_W + 2;
    // Fill counter runs from zero to three blocks minus one.
    localparam int FILL_W = $clog2(3 * BLOCK_LEN);

    localparam logic [FILL_W-1:0] FILL_ONE   = FILL_W'(BLOCK_LEN);
    localparam logic [FILL_W-1:0] FILL_TWO   = FILL_W'(2 * BLOCK_LEN);
    localparam logic [FILL_W-1:0] FILL_LAST  = FILL_W'(3 * BLOCK_LEN - 1);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_HACK_THRESHOLD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_NOMINAL_LEVEL  = CFG_INDEX_W'(1);

    // Reset values of the configuration registers.
    localparam logic [HACK_W-1:0]         HACK_RESET  = HACK_W'(6554);
    localparam logic signed [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(65536);

    typedef enum logic [2:0] {
        VERDICT_CONSTANT = 3'd0,
        VERDICT_HACK     = 3'd1,
        VERDICT_GRADUAL  = 3'd2,
        VERDICT_BLIP     = 3'd3,
        VERDICT_NA       = 3'd4
    } verdict_t;

    typedef struct packed {
        logic signed [FACTOR_W-1:0] factor;
        logic [SECONDS_W-1:0]       now_seconds;
    } sample_t;

    typedef struct packed {
        verdict_t             verdict;
        logic [SECONDS_W-1:0] middle_start;
    } report_t;

    // The three block sums handed to the classifier.
    typedef struct packed {
        logic signed [SUM_W-1:0] first;
        logic signed [SUM_W-1:0] second;
        logic signed [SUM_W-1:0] third;
    } block_sums_t;

endpackage

[hw/rtl/tawac_classify.sv]
// Verdict logic: compares three block sums against thresholds scaled by the block length.
module tawac_classify (
    input  tawac_pkg::block_sums_t             sums,
    input  logic [tawac_pkg::HACK_W-1:0]       hack_threshold,
    input  logic signed [tawac_pkg::LEVEL_W-1:0] nominal_level,
    output tawac_pkg::verdict_t                verdict
);
    import tawac_pkg::*;

    localparam logic signed [CMP_W-1:0] LEN_C = CMP_W'(BLOCK_LEN);

    logic signed [CMP_W-1:0] s1;
    logic signed [CMP_W-1:0] s2;
    logic signed [CMP_W-1:0] s3;
    logic signed [CMP_W-1:0] thr;
    logic signed [CMP_W-1:0] lvl;
    logic signed [CMP_W-1:0] d12;
    logic signed [CMP_W-1:0] d23;

    // Widen everything to one signed comparison width.
    always_comb
    begin
        s1  = CMP_W'(sums.first);
        s2  = CMP_W'(sums.second);
        s3  = CMP_W'(sums.third);
        thr = $signed(CMP_W'(hack_threshold)) * LEN_C;
        lvl = CMP_W'(nominal_level) * LEN_C;
        d12 = (s1 > s2) ? (s1 - s2) : (s2 - s1);
        d23 = (s2 > s3) ? (s2 - s3) : (s3 - s2);
    end

    // Tests in priority order; the first that holds gives the verdict.
    always_comb
    begin
        if ((s1 == s2) && (s1 == s3))
        begin
            verdict = VERDICT_CONSTANT;
        end
        else if ((d12 > thr) || (d23 > thr))
        begin
            verdict = VERDICT_HACK;
        end
        else if ((s1 != lvl) && (s2 != lvl) && (s3 != lvl))
        begin
            verdict = VERDICT_GRADUAL;
        end
        else if ((s1 == lvl) && (s3 == lvl) && ((d12 < thr) || (d23 < thr)))
        begin
            verdict = VERDICT_BLIP;
        end
        else
        begin
            verdict = VERDICT_NA;
        end
    end

endmodule

[hw/rtl/three_window_average_anomaly_classifier.sv]
// Top level of the three-window average anomaly classifier.
//
// Usage: each sample transaction carries a signed Q8.16 factor and a seconds
// timestamp; it is accepted at a clock edge where sample_valid is high and
// sample_stall is low. Samples fill three consecutive blocks of BLOCK_LEN
// samples, of which only the sums and start times are kept. The sample that
// fills the third block produces one report transaction (verdict and, for a
// hack verdict, the middle block start time); the blocks then shift by one, so
// after the first report every BLOCK_LEN samples give another.
// The completing sample's final sums are captured at the edge that takes it;
// the verdict is registered into the report register once that is free.
// Throughput: one sample per cycle while sample_stall is low. sample_stall
// rises only when a captured set of sums cannot move into the report
// register because the receiver holds report_stall high over a report that
// is still waiting. Configuration writes (cfg_valid with cfg_ready, always
// high) are to be made by the user only while the block is idle; the block
// does not enforce this. Reset clears the block sums, fill count and valid
// flags and loads the threshold and nominal level defaults; no clearing pass.
module three_window_average_anomaly_classifier (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  tawac_pkg::sample_t                 sample_data,
    output logic                               report_valid,
    input  logic                               report_stall,
    output tawac_pkg::report_t                 report_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tawac_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tawac_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tawac_pkg::*;

    // Configuration registers.
    logic [HACK_W-1:0]         hack_reg;
    logic signed [LEVEL_W-1:0] level_reg;

    // Block accumulation state.
    logic signed [SUM_W-1:0]   first_sum_reg;
    logic signed [SUM_W-1:0]   second_sum_reg;
    logic signed [SUM_W-1:0]   third_sum_reg;
    logic [FILL_W-1:0]         fill_reg;
    logic [SECONDS_W-1:0]      second_start_reg;
    logic [SECONDS_W-1:0]      third_start_reg;

    // Captured sums waiting for classification.
    logic                      snap_valid_reg;
    block_sums_t               snap_sums_reg;
    logic [SECONDS_W-1:0]      snap_start_reg;

    // Report register.
    logic                      report_valid_reg;
    report_t                   report_reg;

    logic                      report_load;
    logic                      snap_move;
    logic                      sample_take;
    logic                      block_done;
    logic signed [SUM_W-1:0]   factor_ext;
    verdict_t                  verdict;

    // Handshake and pipeline movement.
    always_comb
    begin
        report_load  = !report_valid_reg || !report_stall;
        snap_move    = snap_valid_reg && report_load;
        sample_stall = snap_valid_reg && !report_load;
        sample_take  = sample_valid && !sample_stall;
        block_done   = sample_take && (fill_reg == FILL_LAST);
        factor_ext   = SUM_W'(sample_data.factor);
    end

    assign cfg_ready    = 1'b1;
    assign report_valid = report_valid_reg;
    assign report_data  = report_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hack_reg  <= HACK_RESET;
            level_reg <= LEVEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HACK_THRESHOLD: hack_reg  <= cfg_data[HACK_W-1:0];
                CFG_NOMINAL_LEVEL:  level_reg <= $signed(cfg_data[LEVEL_W-1:0]);
                default:            ;
            endcase
        end
    end

    // Block filling: each sample adds into the block that the fill count selects.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sum_reg    <= '0;
            second_sum_reg   <= '0;
            third_sum_reg    <= '0;
            fill_reg         <= '0;
            second_start_reg <= '0;
            third_start_reg  <= '0;
        end
        else if (sample_take)
        begin
            if (fill_reg < FILL_ONE)
            begin
                first_sum_reg <= first_sum_reg + factor_ext;
                fill_reg      <= fill_reg + FILL_W'(1);
            end
            else if (fill_reg < FILL_TWO)
            begin
                if (fill_reg == FILL_ONE)
                begin
                    second_start_reg <= sample_data.now_seconds;
                end
                second_sum_reg <= second_sum_reg + factor_ext;
                fill_reg       <= fill_reg + FILL_W'(1);
            end
            else if (block_done)
            begin
                // Third block full: shift the blocks down by one.
                first_sum_reg    <= second_sum_reg;
                second_sum_reg   <= third_sum_reg + factor_ext;
                third_sum_reg    <= '0;
                second_start_reg <= third_start_reg;
                third_start_reg  <= '0;
                fill_reg         <= FILL_TWO;
            end
            else
            begin
                if (fill_reg == FILL_TWO)
                begin
                    third_start_reg <= sample_data.now_seconds;
                end
                third_sum_reg <= third_sum_reg + factor_ext;
                fill_reg      <= fill_reg + FILL_W'(1);
            end
        end
    end

    // Capture stage: hold the final sums of a completed window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (block_done)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (snap_move)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (block_done)
        begin
            snap_sums_reg.first  <= first_sum_reg;
            snap_sums_reg.second <= second_sum_reg;
            snap_sums_reg.third  <= third_sum_reg + factor_ext;
            snap_start_reg       <= second_start_reg;
        end
    end

    tawac_classify u_classify (
        .sums           (snap_sums_reg),
        .hack_threshold (hack_reg),
        .nominal_level  (level_reg),
        .verdict        (verdict)
    );

    // Report stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_valid_reg <= 1'b0;
        end
        else if (report_load)
        begin
            report_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_move)
        begin
            report_reg.verdict      <= verdict;
            report_reg.middle_start <= (verdict == VERDICT_HACK) ? snap_start_reg : '0;
        end
    end

    // The window that completes a block always leaves the counter at two blocks.
    assert property (@(posedge clk) disable iff (!rst_n)
        block_done |=> (fill_reg == FILL_TWO) && snap_valid_reg)
        else $error("fill count not rewound after a completed window");

    // A sample is never taken while captured sums are stuck behind the report.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_take |-> !snap_valid_reg || report_load)
        else $error("sample accepted over held sums");

    // Captured sums hold while they cannot move on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid_reg && !report_load) |=> snap_valid_reg && $stable(snap_sums_reg))
        else $error("captured sums changed while stalled");

    // Only a hack verdict carries a start time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (report_valid_reg && (report_reg.verdict != VERDICT_HACK))
            |-> (report_reg.middle_start == '0))
        else $error("start time reported without a hack verdict");

endmodule
